// ===== src/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes of the periodic task tick scheduler: item structs,
// command kinds, task states, table entry and controller/datapath links.
// ----------------------------------------------------------------------------
package ptts_pkg;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_CREATE  = 3'd1,
        KIND_SUSPEND = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_DELETE  = 3'd4,
        KIND_DELAY   = 3'd5
    } kind_t;

    localparam logic [1:0] ST_READY     = 2'd0;
    localparam logic [1:0] ST_SUSPENDED = 2'd1;
    localparam logic [1:0] ST_DELETED   = 2'd2;

    localparam logic [3:0] MAX_RESULTS = 4'd8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  priority_req;
        logic [15:0] period;
        logic [15:0] start_count;
        logic [1:0]  initial_state;
        logic [31:0] hold_ticks;
    } in_t;

    typedef struct packed {
        logic       fired;
        logic [3:0] fire_prio;
        logic       accepted;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] countdown;
        logic [31:0] delay;
        logic [1:0]  state;
    } entry_t;

    typedef struct packed {
        logic cap;
        logic walk_step;
        logic cmd_exec;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic out_free;
        logic need_push;
        logic walk_end;
    } dp_status_t;

endpackage

// ===== src/ptts_ram.sv =====
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptts_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptts_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptts_ctrl
// Controller of the scheduler: takes an item, then runs either one command
// read-modify-write or a walk over all task slots followed by a flush.
// ----------------------------------------------------------------------------
module ptts_ctrl
    import ptts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CMD_EXEC,
        WALK,
        FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.cap    = 1'b1;
                    state_next = status.in_tick ? WALK : CMD_EXEC;
                end
            end
            CMD_EXEC: begin
                if (status.out_free) begin
                    cmd.cmd_exec = 1'b1;
                    state_next   = IDLE;
                end
            end
            WALK: begin
                if (!status.need_push || status.out_free) begin
                    cmd.walk_step = 1'b1;
                    if (status.walk_end) begin
                        state_next = FLUSH;
                    end
                end
            end
            FLUSH: begin
                if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
        ready_next = (state_next == IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

// ===== src/ptts_dp.sv =====
// ----------------------------------------------------------------------------
// ptts_dp
// Datapath of the scheduler: input register, task table memory with valid
// bits, slot update logic, pending firing and output register.
// ----------------------------------------------------------------------------
module ptts_dp
    import ptts_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_t        s_data,
    output out_t       m_data,
    output logic       m_valid,
    input  logic       m_ready,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status
);

    localparam int SW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int EW = $bits(entry_t);

    in_t            in_reg;
    logic [SW-1:0]  cnt_reg;
    logic [3:0]     n_reg;
    logic           pend_valid_reg;
    logic [3:0]     pend_prio_reg;
    logic           m_valid_reg;
    out_t           m_data_reg;
    logic           rd_valid_reg;
    logic [TASKS-1:0] valid_reg;

    logic           rd_en, wr_en, push;
    logic [SW-1:0]  rd_addr, wr_addr;
    entry_t         wr_entry, rd_entry;
    logic [EW-1:0]  ram_q;
    out_t           push_data;

    logic [7:0]     s_prio_m1, in_prio_m1, walk_prio;
    logic [SW-1:0]  s_slot, in_slot;
    logic           cmd_ok;
    logic           out_free;

    // walk update
    logic           delay_zero, dec, fire, report;
    logic [1:0]     w_state;
    logic [15:0]    cd_m1;
    entry_t         walk_entry, cmd_entry;

    assign s_prio_m1  = {4'd0, s_data.priority_req} - 8'd1;
    assign in_prio_m1 = {4'd0, in_reg.priority_req} - 8'd1;
    assign s_slot     = s_prio_m1[SW-1:0];
    assign in_slot    = in_prio_m1[SW-1:0];
    assign walk_prio  = 8'(cnt_reg) + 8'd1;

    assign cmd_ok = (in_reg.kind != KIND_TICK) && (in_reg.kind <= KIND_DELAY)
                    && (in_reg.priority_req != 4'd0)
                    && ({4'd0, in_reg.priority_req} <= 8'(TASKS));

    assign out_free = !m_valid_reg || m_ready;
    assign rd_entry = rd_valid_reg ? entry_t'(ram_q) : '0;

    always_comb begin
        delay_zero = (rd_entry.delay == 32'd0);
        w_state    = delay_zero ? ST_READY : rd_entry.state;
        dec        = (rd_entry.period != 16'd0) && (w_state == ST_READY)
                     && (rd_entry.countdown != 16'd0);
        cd_m1      = rd_entry.countdown - 16'd1;
        fire       = dec && (cd_m1 == 16'd0);
        report     = fire && (n_reg < MAX_RESULTS);

        walk_entry.period    = rd_entry.period;
        walk_entry.delay     = delay_zero ? 32'd0 : rd_entry.delay - 32'd1;
        walk_entry.state     = w_state;
        walk_entry.countdown = fire ? rd_entry.period
                                    : (dec ? cd_m1 : rd_entry.countdown);
    end

    always_comb begin
        cmd_entry = rd_entry;
        case (in_reg.kind)
            KIND_CREATE: begin
                cmd_entry.period    = in_reg.period;
                cmd_entry.countdown = in_reg.start_count;
                cmd_entry.state     = in_reg.initial_state;
            end
            KIND_SUSPEND: cmd_entry.state = ST_SUSPENDED;
            KIND_RESUME: begin
                if (rd_entry.state == ST_SUSPENDED) begin
                    cmd_entry.state = ST_READY;
                end
            end
            KIND_DELETE: begin
                cmd_entry.period = 16'd0;
                cmd_entry.state  = ST_DELETED;
            end
            KIND_DELAY: begin
                cmd_entry.delay = in_reg.hold_ticks;
                cmd_entry.state = ST_SUSPENDED;
            end
            default: cmd_entry = rd_entry;
        endcase
    end

    assign status.in_tick   = (s_data.kind == KIND_TICK);
    assign status.out_free  = out_free;
    assign status.need_push = report && pend_valid_reg;
    assign status.walk_end  = (cnt_reg == SW'(TASKS - 1));

    assign rd_en    = cmd.cap || (cmd.walk_step && !status.walk_end);
    assign rd_addr  = cmd.cap ? (status.in_tick ? '0 : s_slot) : SW'(cnt_reg + 1'b1);
    assign wr_en    = cmd.walk_step || (cmd.cmd_exec && cmd_ok);
    assign wr_addr  = cmd.walk_step ? cnt_reg : in_slot;
    assign wr_entry = cmd.walk_step ? walk_entry : cmd_entry;
    assign push     = (cmd.walk_step && status.need_push) || cmd.cmd_exec || cmd.flush;

    always_comb begin
        push_data = '0;
        if (cmd.cmd_exec) begin
            push_data.accepted = cmd_ok;
            push_data.last     = 1'b1;
        end else if (cmd.flush) begin
            push_data.fired     = pend_valid_reg;
            push_data.fire_prio = pend_valid_reg ? pend_prio_reg : 4'd0;
            push_data.accepted  = 1'b1;
            push_data.last      = 1'b1;
        end else begin
            push_data.fired     = 1'b1;
            push_data.fire_prio = pend_prio_reg;
            push_data.accepted  = 1'b1;
        end
    end

    ptts_ram #(
        .WIDTH (EW),
        .DEPTH (TASKS)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            in_reg <= s_data;
        end
        if (push) begin
            m_data_reg <= push_data;
        end
        if (cmd.walk_step && report) begin
            pend_prio_reg <= walk_prio[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (cmd.cap) begin
                cnt_reg        <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end else if (cmd.walk_step) begin
                if (!status.walk_end) begin
                    cnt_reg <= SW'(cnt_reg + 1'b1);
                end
                if (report) begin
                    n_reg          <= n_reg + 4'd1;
                    pend_valid_reg <= 1'b1;
                end
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed while output register busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_RESULTS)
        else $error("reported firing count above limit");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> !pend_valid_reg)
        else $error("pending firing survived flush");

    a_idle_prio_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.fired |-> m_data_reg.fire_prio == 4'd0)
        else $error("non-firing result carries a priority");

endmodule

// ===== src/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Periodic task scheduler with a priority-indexed task table, driven by
// tick and task command items.
// ----------------------------------------------------------------------------
// A command item (create, suspend, resume, delete, delay) returns one
// result. A tick item is taken, then the walk reads and updates each slot
// of the task table memory in priority order, and then the final result is
// given. Each firing gives one result (at most eight per tick, the final one
// marked last); a tick with no firing gives one result with fired low. A
// command, the walk and the final result wait while the result side holds
// off an earlier result. One item is in work at a time.
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ptts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ptts_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic task tick scheduler. Task commands and
// ticks go in over a valid/ready channel with random gaps. A scoreboard keeps
// its own copy of the task table and predicts every firing and command reply.
// Each result is checked field by field against the oldest prediction, while
// the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import ptts_pkg::*;

    localparam int NUM_TASKS = 8;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [1:0] ST_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 86;

    class task_table_scoreboard;
        logic [15:0] period_of [NUM_TASKS];
        logic [15:0] count_of [NUM_TASKS];
        logic [31:0] wait_of [NUM_TASKS];
        logic [1:0]  state_of [NUM_TASKS];
        out_t        due_results [$];
        int          mismatches;

        function new();
            for (int s = 0; s < NUM_TASKS; s++) begin
                period_of[s] = '0;
                count_of[s] = '0;
                wait_of[s] = '0;
                state_of[s] = ST_READY;
            end
            mismatches = 0;
        endfunction

        function out_t make_result(logic fired, logic [3:0] prio, logic acc, logic fin);
            out_t r;
            r.fired = fired;
            r.fire_prio = prio;
            r.accepted = acc;
            r.last = fin;
            return r;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // walk the table, or apply one command, and queue what the block should send
        function void note_item(in_t it);
            int   fired_prios [$];
            int   s;
            logic ok;
            if (it.kind == KIND_TICK) begin
                for (s = 0; s < NUM_TASKS; s++) begin
                    if (wait_of[s] == 0)
                        state_of[s] = ST_READY;
                    else
                        wait_of[s] = wait_of[s] - 32'd1;
                    if (period_of[s] != 0 && state_of[s] == ST_READY && count_of[s] != 0) begin
                        count_of[s] = count_of[s] - 16'd1;
                        if (count_of[s] == 0) begin
                            count_of[s] = period_of[s];
                            if (fired_prios.size() < int'(MAX_RESULTS))
                                fired_prios.push_back(s + 1);
                        end
                    end
                end
                if (fired_prios.size() == 0) begin
                    due_results.push_back(make_result(1'b0, 4'd0, 1'b1, 1'b1));
                end else begin
                    for (int i = 0; i < fired_prios.size(); i++)
                        due_results.push_back(make_result(1'b1, 4'(fired_prios[i]), 1'b1,
                                                          i == fired_prios.size() - 1));
                end
            end else begin
                ok = (it.kind <= KIND_DELAY) && (it.priority_req >= 1) &&
                     (int'(it.priority_req) <= NUM_TASKS);
                if (ok) begin
                    s = int'(it.priority_req) - 1;
                    case (it.kind)
                        KIND_CREATE: begin
                            period_of[s] = it.period;
                            count_of[s] = it.start_count;
                            state_of[s] = it.initial_state;
                        end
                        KIND_SUSPEND: begin
                            state_of[s] = ST_SUSPENDED;
                        end
                        KIND_RESUME: begin
                            if (state_of[s] == ST_SUSPENDED)
                                state_of[s] = ST_READY;
                        end
                        KIND_DELETE: begin
                            period_of[s] = '0;
                            state_of[s] = ST_DELETED;
                        end
                        default: begin
                            wait_of[s] = it.hold_ticks;
                            state_of[s] = ST_SUSPENDED;
                        end
                    endcase
                end
                due_results.push_back(make_result(1'b0, 4'd0, ok, 1'b1));
            end
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (due_results.size() == 0) begin
                $error("unexpected result: fired %0d fire_prio %0d accepted %0d last %0d",
                       got.fired, got.fire_prio, got.accepted, got.last);
                mismatches++;
                return;
            end
            exp = due_results.pop_front();
            if (got.fired !== exp.fired) begin
                $error("fired: expected %0d, got %0d", exp.fired, got.fired);
                mismatches++;
            end
            if (got.fire_prio !== exp.fire_prio) begin
                $error("fire_prio: expected %0d, got %0d", exp.fire_prio,
                       got.fire_prio);
                mismatches++;
            end
            if (got.accepted !== exp.accepted) begin
                $error("accepted: expected %0d, got %0d", exp.accepted, got.accepted);
                mismatches++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    task_table_scoreboard sb = new();
    bit quiet;
    int gap_ahead;

    periodic_task_tick_scheduler #(
        .TASKS(NUM_TASKS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_t make_item(logic [2:0] kind, logic [3:0] prio, logic [15:0] per,
                                      logic [15:0] fd, logic [1:0] st, logic [31:0] ticks);
        in_t it;
        it.kind = kind;
        it.priority_req = prio;
        it.period = per;
        it.start_count = fd;
        it.initial_state = st;
        it.hold_ticks = ticks;
        return it;
    endfunction

    // random filler in every field the kind does not use
    function automatic in_t rand_item(logic [2:0] kind, logic [3:0] prio);
        return make_item(kind, prio, 16'($urandom), 16'($urandom), 2'($urandom), $urandom);
    endfunction

    // valid stays up into the next item when no gap follows
    task automatic send_item(in_t it);
        if (gap_ahead > 0)
            repeat (gap_ahead) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        gap_ahead = pick_gap();
        if (gap_ahead > 0)
            s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        if (gap_ahead == 0)
            s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    initial begin : rx_side
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin : stimulus
        in_t         it;
        int          r;
        logic [3:0]  prio;
        logic [15:0] per;
        logic [15:0] fd;
        logic [1:0]  st;
        logic [31:0] ticks;

        quiet = 1'b0;
        gap_ahead = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, full table firing, rejects, state corner cases
        send_item(rand_item(KIND_TICK, 4'($urandom)));
        for (int p = 1; p <= NUM_TASKS; p++)
            send_item(make_item(KIND_CREATE, 4'(p), 16'd1, 16'd1, ST_READY, $urandom));
        send_item(rand_item(KIND_TICK, 4'($urandom)));
        send_item(make_item(KIND_CREATE, 4'd0, 16'hffff, 16'hffff, ST_READY, $urandom));
        send_item(make_item(KIND_CREATE, 4'(NUM_TASKS + 1), 16'd1, 16'd1, ST_READY, '1));
        send_item(rand_item(KIND_SUSPEND, 4'hf));
        send_item(rand_item(KIND_SPARE_A, 4'd1));
        send_item(rand_item(KIND_SPARE_B, 4'd2));
        send_item(rand_item(KIND_SUSPEND, 4'd2));
        send_item(rand_item(KIND_RESUME, 4'd4));
        send_item(make_item(KIND_DELAY, 4'd3, 16'($urandom), 16'($urandom), 2'($urandom),
                            32'd2));
        send_item(make_item(KIND_DELAY, 4'd8, 16'($urandom), 16'($urandom), 2'($urandom),
                            32'hffff_ffff));
        send_item(make_item(KIND_CREATE, 4'd5, 16'hffff, 16'hffff, ST_UNUSED, '0));
        send_item(rand_item(KIND_DELETE, 4'd1));
        repeat (3)
            send_item(rand_item(KIND_TICK, 4'($urandom)));
        wait_drained();

        // random: mostly well-formed commands on valid slots, ticks in between
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = ((i / 25) % 2) == 1;
            r = $urandom_range(0, 99);
            prio = 4'($urandom_range(1, NUM_TASKS));
            if (r < 35) begin
                it = rand_item(KIND_TICK, 4'($urandom));
            end else if (r < 55) begin
                per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                fd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
                st = ($urandom_range(0, 4) == 0) ? 2'($urandom) : ST_READY;
                it = make_item(KIND_CREATE, prio, per, fd, st, $urandom);
            end else if (r < 63) begin
                it = rand_item(KIND_SUSPEND, prio);
            end else if (r < 71) begin
                it = rand_item(KIND_RESUME, prio);
            end else if (r < 77) begin
                it = rand_item(KIND_DELETE, prio);
            end else if (r < 88) begin
                ticks = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5));
                it = make_item(KIND_DELAY, prio, 16'($urandom), 16'($urandom), 2'($urandom),
                               ticks);
            end else if (r < 94) begin
                prio = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(NUM_TASKS + 1, 15));
                it = rand_item(3'($urandom_range(1, 7)), prio);
            end else begin
                it = rand_item($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B,
                               4'($urandom));
            end
            send_item(it);
            if (i % 30 == 29)
                wait_drained();
        end

        wait_drained();
        repeat (3 * NUM_TASKS + 10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
